/* sv/bmpdec_pkg.sv */
// bmpdec_pkg: shared codes and types of the bitmap raster pixel decoder
// no dependencies; used by bmpdec_ctrl and the top level
package bmpdec_pkg;

    typedef enum logic [1:0] {
        MODE_PAL  = 2'd0,
        MODE_RGB  = 2'd1,
        MODE_RGBA = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_RASTER  = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // last byte position of a pixel per mode
    localparam logic [1:0] LAST_PHASE_PAL  = 2'd0;
    localparam logic [1:0] LAST_PHASE_RGB  = 2'd2;
    localparam logic [1:0] LAST_PHASE_RGBA = 2'd3;

    typedef struct packed {
        logic       valid;
        logic       pal;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_end;
        logic       image_end;
    } pix_t;

endpackage

/* sv/bmpdec_palette.sv */
// bmpdec_palette: palette memory, one write and one registered read per cycle
// indexes at or above ENTRIES are dropped on write and read back as black
// depends on nothing but its parameter
module bmpdec_palette #(
    parameter int ENTRIES = 256
) (
    input  logic        clk,
    input  logic        wr_en,
    input  logic [7:0]  wr_index,
    input  logic [23:0] wr_data,
    input  logic        rd_en,
    input  logic [7:0]  rd_index,
    output logic [23:0] rd_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [23:0] mem [ENTRIES];
    logic [23:0] rd_data_reg;
    logic        rd_hit_reg;
    logic        wr_hit;
    logic        rd_hit;

    assign wr_hit = ({1'b0, wr_index} < 9'(ENTRIES));
    assign rd_hit = ({1'b0, rd_index} < 9'(ENTRIES));

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_hit)
        begin
            mem[wr_index[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_index[AW-1:0]];
            rd_hit_reg  <= rd_hit;
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : 24'd0;

endmodule

/* sv/bmpdec_ctrl.sv */
// bmpdec_ctrl: raster sequencer; byte phase, held bytes, pad skip and row/column counters
// emits one pixel descriptor per completed pixel; uses bmpdec_pkg
module bmpdec_ctrl #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        raster_byte,
    input  logic [1:0]        pixel_mode,
    input  logic [12:0]       image_width,
    input  logic [12:0]       image_height,
    output bmpdec_pkg::pix_t  pix
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = (CW + 1 > 14) ? CW + 1 : 14;
    localparam int HW = (RW + 1 > 14) ? RW + 1 : 14;

    logic [1:0]    phase_reg, phase_next;
    logic [23:0]   held_reg, held_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [1:0]    pad_reg, pad_next;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [1:0]    last_phase;
    logic          col_wrap;
    logic          row_wrap;

    // clamp the size registers into 1..MAX
    always_comb
    begin
        w_eff = WW'(image_width);
        if (image_width == 13'd0)
            w_eff = WW'(1);
        else if (w_eff > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        h_eff = HW'(image_height);
        if (image_height == 13'd0)
            h_eff = HW'(1);
        else if (h_eff > HW'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
    end

    always_comb
    begin
        unique case (pixel_mode)
            bmpdec_pkg::MODE_PAL:  last_phase = bmpdec_pkg::LAST_PHASE_PAL;
            bmpdec_pkg::MODE_RGB:  last_phase = bmpdec_pkg::LAST_PHASE_RGB;
            default:               last_phase = bmpdec_pkg::LAST_PHASE_RGBA;
        endcase
    end

    assign col_wrap = (WW'(col_reg) + WW'(1) >= w_eff);
    assign row_wrap = (HW'(row_reg) + HW'(1) >= h_eff);

    always_comb
    begin
        phase_next    = phase_reg;
        held_next     = held_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pad_next      = pad_reg;
        pix.valid     = 1'b0;
        pix.pal       = (pixel_mode == bmpdec_pkg::MODE_PAL);
        pix.red       = raster_byte;
        pix.green     = held_reg[7:0];
        pix.blue      = held_reg[15:8];
        pix.alpha     = bmpdec_pkg::ALPHA_OPAQUE;
        pix.row_end   = 1'b0;
        pix.image_end = 1'b0;
        if (pixel_mode == bmpdec_pkg::MODE_RGBA)
        begin
            pix.red   = held_reg[7:0];
            pix.green = held_reg[15:8];
            pix.blue  = held_reg[23:16];
            pix.alpha = raster_byte;
        end
        if (fire && pixel_mode != bmpdec_pkg::MODE_NONE)
        begin
            if (pad_reg != 2'd0)
            begin
                pad_next = pad_reg - 2'd1;
            end
            else if (phase_reg < last_phase)
            begin
                held_next  = {held_reg[15:0], raster_byte};
                phase_next = phase_reg + 2'd1;
            end
            else
            begin
                pix.valid  = 1'b1;
                phase_next = 2'd0;
                held_next  = 24'd0;
                if (col_wrap)
                begin
                    pix.row_end = 1'b1;
                    col_next    = '0;
                    unique case (pixel_mode)
                        bmpdec_pkg::MODE_PAL: pad_next = 2'd0 - w_eff[1:0];
                        bmpdec_pkg::MODE_RGB: pad_next = w_eff[1:0];
                        default:              pad_next = 2'd0;
                    endcase
                    if (row_wrap)
                    begin
                        pix.image_end = 1'b1;
                        row_next      = '0;
                    end
                    else
                    begin
                        row_next = row_reg + RW'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            held_reg  <= 24'd0;
            col_reg   <= '0;
            row_reg   <= '0;
            pad_reg   <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pad_reg   <= pad_next;
        end
    end

endmodule

/* sv/bmp_raster_pixel_decoder_core.sv */
// bmp_raster_pixel_decoder_core: top level of the bitmap raster pixel decoder
// depends on bmpdec_pkg, bmpdec_ctrl and bmpdec_palette
//
// Takes one item per clock while in_ready is high: a palette write (op 0) or one raster
// byte (op 1), and turns raster bytes of an uncompressed bitmap into RGBA pixels in
// 8 bpp palettized, 24 bpp or 32 bpp mode, skipping row pad bytes and flagging row and
// image ends. The sustained rate is one item per cycle while the output is not stalled,
// with no clearing pass after reset. The synchronous palette read and stage 1 load at the
// edge accepting a pixel's last byte; the output register loads when stage 1 advances.
// A palette write is visible to any raster byte accepted after it. The user must write
// configuration via the cfg port while the block is idle, which is not enforced.
module bmp_raster_pixel_decoder_core #(
    parameter int MAX_WIDTH       = 4096,
    parameter int MAX_HEIGHT      = 4096,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  entry_red,
    input  logic [7:0]  entry_green,
    input  logic [7:0]  entry_blue,
    input  logic [7:0]  raster_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic        row_end,
    output logic        image_end
);

    logic [1:0]       mode_reg;
    logic [12:0]      width_reg;
    logic [12:0]      height_reg;

    logic             accept;
    logic             raster_fire;
    bmpdec_pkg::pix_t pix;
    logic [23:0]      pal_rgb;

    logic             s1_valid_reg, s1_valid_next;
    bmpdec_pkg::pix_t s1_reg;
    logic             s1_adv;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       red_reg, green_reg, blue_reg, alpha_reg;
    logic             row_end_reg, image_end_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= bmpdec_pkg::MODE_RGB;
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bmpdec_pkg::REG_MODE:   mode_reg   <= cfg_data[1:0];
                bmpdec_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                bmpdec_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // stage 1 may take a new item when empty or moving into the output register
    assign s1_adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready    = !s1_valid_reg || s1_adv;
    assign accept      = in_valid && in_ready;
    assign raster_fire = accept && (op == bmpdec_pkg::OP_RASTER);

    bmpdec_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (raster_fire),
        .raster_byte  (raster_byte),
        .pixel_mode   (mode_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .pix          (pix)
    );

    // read only for emitted palette pixels so the data holds while stage 1 stalls
    bmpdec_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk      (clk),
        .wr_en    (accept && (op == bmpdec_pkg::OP_PALETTE)),
        .wr_index (entry_index),
        .wr_data  ({entry_red, entry_green, entry_blue}),
        .rd_en    (pix.valid && pix.pal),
        .rd_index (raster_byte),
        .rd_data  (pal_rgb)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pix.valid)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.valid)
        begin
            s1_reg <= pix;
        end
        if (s1_adv)
        begin
            if (s1_reg.pal)
            begin
                red_reg   <= pal_rgb[23:16];
                green_reg <= pal_rgb[15:8];
                blue_reg  <= pal_rgb[7:0];
            end
            else
            begin
                red_reg   <= s1_reg.red;
                green_reg <= s1_reg.green;
                blue_reg  <= s1_reg.blue;
            end
            alpha_reg     <= s1_reg.alpha;
            row_end_reg   <= s1_reg.row_end;
            image_end_reg <= s1_reg.image_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign alpha     = alpha_reg;
    assign row_end   = row_end_reg;
    assign image_end = image_end_reg;

endmodule
